@@ src/bhc_pkg.sv @@
// shared types and constants of the heart-rate crossfade controller
package bhc_pkg;

	localparam int unsigned BPM_W   = 8;
	localparam int unsigned VOL_W   = 8;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned TICK_W  = 10;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned DATA_W  = 10;
	localparam int unsigned DIV_CNT_W = 3;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} fsm_state_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ACTIVE_THR = 2'd0,
		REG_CALM_THR   = 2'd1,
		REG_FADE_STEPS = 2'd2,
		REG_STEP_MS    = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_CALM   = 1'b0,
		MODE_ACTIVE = 1'b1
	} mode_t;

	localparam logic [BPM_W-1:0]  ACTIVE_THR_RST = 8'd100;
	localparam logic [BPM_W-1:0]  CALM_THR_RST   = 8'd80;
	localparam logic [STEP_W-1:0] FADE_STEPS_RST = 8'd32;
	localparam logic [TICK_W-1:0] STEP_MS_RST    = 10'd50;

endpackage

@@ src/bhc_if.sv @@
// valid/ready channel interfaces for samples, results and register writes
interface bhc_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [bhc_pkg::BPM_W-1:0] bpm;

	modport source (output valid, output cmd, output bpm, input ready);
	modport sink (input valid, input cmd, input bpm, output ready);
endinterface

interface bhc_out_if;
	logic                      valid;
	logic                      ready;
	logic [bhc_pkg::VOL_W-1:0] calm_volume;
	logic [bhc_pkg::VOL_W-1:0] active_volume;
	logic                      mode_now;
	logic                      fading;
	logic                      transition_done;

	modport source (output valid, output calm_volume, output active_volume, output mode_now,
		output fading, output transition_done, input ready);
	modport sink (input valid, input calm_volume, input active_volume, input mode_now,
		input fading, input transition_done, output ready);
endinterface

interface bhc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bhc_pkg::IDX_W-1:0]  index;
	logic [bhc_pkg::DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/bpm_hysteresis_crossfade_top.sv @@
// heart-rate driven calm/active crossfade controller with hysteresis
// a request goes from idle straight to the output state when volumes stay; when a
// volume update runs it passes a multiply state, then compare-subtract divide steps
// no new request is taken until the last result is in the output register; the
// output state holds while an earlier result still waits on a stalled output
// reset: asynchronous, mode calm, volumes full and zero, registers at defaults
module bpm_hysteresis_crossfade_top #(
	parameter int unsigned FULL_VOLUME = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	bhc_in_if.sink          in_ch,
	bhc_out_if.source       out_ch,
	bhc_cfg_if.sink         cfg_ch
);

	localparam int unsigned VW = bhc_pkg::VOL_W;
	localparam int unsigned SW = bhc_pkg::STEP_W;
	localparam int unsigned TW = bhc_pkg::TICK_W;
	localparam logic [VW-1:0] FULL_V = VW'(FULL_VOLUME);

	bhc_pkg::fsm_state_t state_q;

	logic [bhc_pkg::BPM_W-1:0] active_thr_q;
	logic [bhc_pkg::BPM_W-1:0] calm_thr_q;
	logic [SW-1:0]             fade_steps_q;
	logic [TW-1:0]             step_ms_q;

	logic          mode_q;
	logic          fade_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [TW-1:0] tick_q;
	logic [VW-1:0] calm_lvl_q;
	logic [VW-1:0] active_lvl_q;

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvd_q;
	logic [bhc_pkg::DIV_CNT_W-1:0] cnt_q;

	logic                out_valid_q;
	logic [VW-1:0]       out_calm_q;
	logic [VW-1:0]       out_active_q;
	logic                out_mode_q;
	logic                out_fade_q;
	logic                out_done_q;

	logic          accept;
	logic          go;
	logic [TW-1:0] period;
	logic [TW-1:0] tick_inc;
	logic [SW-1:0] step_clamp;
	logic [2*VW-1:0] prod;
	logic [VW:0]   trial;
	logic          ge;
	logic [VW-1:0] diff;
	logic [VW-1:0] quot;

	assign in_ch.ready  = (state_q == bhc_pkg::S_IDLE);
	assign accept       = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	assign go = ((mode_q == bhc_pkg::MODE_CALM) && (in_ch.bpm >= active_thr_q)) ||
		((mode_q == bhc_pkg::MODE_ACTIVE) && (in_ch.bpm <= calm_thr_q));
	assign period     = (step_ms_q == '0) ? TW'(1) : step_ms_q;
	assign tick_inc   = tick_q + TW'(1);
	assign step_clamp = (step_q > fade_steps_q) ? fade_steps_q : step_q;
	assign prod       = (2*VW)'(FULL_V) * (2*VW)'(step_clamp);
	assign trial      = {rem_q, dvd_q[VW-1]};
	assign ge         = (trial >= {1'b0, fade_steps_q});
	assign diff       = trial[VW-1:0] - fade_steps_q;
	assign quot       = {dvd_q[VW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_thr_q <= bhc_pkg::ACTIVE_THR_RST;
			calm_thr_q   <= bhc_pkg::CALM_THR_RST;
			fade_steps_q <= bhc_pkg::FADE_STEPS_RST;
			step_ms_q    <= bhc_pkg::STEP_MS_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				bhc_pkg::REG_ACTIVE_THR: active_thr_q <= cfg_ch.data[bhc_pkg::BPM_W-1:0];
				bhc_pkg::REG_CALM_THR:   calm_thr_q   <= cfg_ch.data[bhc_pkg::BPM_W-1:0];
				bhc_pkg::REG_FADE_STEPS: fade_steps_q <= (cfg_ch.data[SW-1:0] == '0) ?
					SW'(1) : cfg_ch.data[SW-1:0];
				bhc_pkg::REG_STEP_MS:    step_ms_q    <= cfg_ch.data[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bhc_pkg::S_IDLE;
			mode_q       <= bhc_pkg::MODE_CALM;
			fade_q       <= 1'b0;
			done_q       <= 1'b0;
			step_q       <= '0;
			tick_q       <= '0;
			calm_lvl_q   <= FULL_V;
			active_lvl_q <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != bhc_pkg::S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bhc_pkg::S_IDLE: begin
					if (accept) begin
						if (in_ch.cmd == bhc_pkg::CMD_SAMPLE) begin
							done_q <= 1'b0;
							if (go) begin
								fade_q  <= 1'b1;
								step_q  <= '0;
								tick_q  <= '0;
								state_q <= bhc_pkg::S_MUL;
							end else begin
								state_q <= bhc_pkg::S_OUT;
							end
						end else if (fade_q && (tick_inc >= period)) begin
							tick_q <= '0;
							if (step_q >= fade_steps_q) begin
								mode_q  <= ~mode_q;
								fade_q  <= 1'b0;
								step_q  <= '0;
								done_q  <= 1'b1;
								state_q <= bhc_pkg::S_OUT;
							end else begin
								done_q  <= 1'b0;
								step_q  <= step_q + SW'(1);
								state_q <= bhc_pkg::S_MUL;
							end
						end else begin
							done_q  <= 1'b0;
							state_q <= bhc_pkg::S_OUT;
							if (fade_q) begin
								tick_q <= tick_inc;
							end
						end
					end
				end
				bhc_pkg::S_MUL: begin
					rem_q   <= prod[2*VW-1:VW];
					dvd_q   <= prod[VW-1:0];
					cnt_q   <= '0;
					state_q <= bhc_pkg::S_DIV;
				end
				bhc_pkg::S_DIV: begin
					rem_q <= ge ? diff : trial[VW-1:0];
					dvd_q <= quot;
					cnt_q <= cnt_q + bhc_pkg::DIV_CNT_W'(1);
					if (cnt_q == '1) begin
						if (mode_q == bhc_pkg::MODE_CALM) begin
							active_lvl_q <= quot;
							calm_lvl_q   <= FULL_V - quot;
						end else begin
							calm_lvl_q   <= quot;
							active_lvl_q <= FULL_V - quot;
						end
						state_q <= bhc_pkg::S_OUT;
					end
				end
				bhc_pkg::S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_calm_q   <= calm_lvl_q;
						out_active_q <= active_lvl_q;
						out_mode_q   <= mode_q;
						out_fade_q   <= fade_q;
						out_done_q   <= done_q;
						state_q      <= bhc_pkg::S_IDLE;
					end
				end
				default: state_q <= bhc_pkg::S_IDLE;
			endcase
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.calm_volume     = out_calm_q;
	assign out_ch.active_volume   = out_active_q;
	assign out_ch.mode_now        = out_mode_q;
	assign out_ch.fading          = out_fade_q;
	assign out_ch.transition_done = out_done_q;

endmodule

@@ src/bhc_checker.sv @@
// port-level checks of the crossfade controller and their binding
module bhc_checker #(
	parameter int unsigned FULL_VOLUME = 128
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bhc_pkg::VOL_W-1:0] calm_volume,
	input logic [bhc_pkg::VOL_W-1:0] active_volume,
	input logic                      mode_now,
	input logic                      fading,
	input logic                      transition_done
);

	localparam logic [bhc_pkg::VOL_W:0] FULL_SUM = (bhc_pkg::VOL_W+1)'(FULL_VOLUME);

	logic seen_q;
	logic last_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_mode_q <= bhc_pkg::MODE_CALM;
		end else if (out_valid && out_ready) begin
			seen_q      <= 1'b1;
			last_mode_q <= mode_now;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_done_ends_fade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transition_done |-> !fading)
		else $error("transition done while still fading");

	a_volume_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, calm_volume} + {1'b0, active_volume}) == FULL_SUM)
		else $error("volumes do not add up to full scale");

	a_mode_flip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && seen_q |->
			((mode_now != last_mode_q) == transition_done))
		else $error("mode changed without transition done");

endmodule

bind bpm_hysteresis_crossfade_top bhc_checker #(
	.FULL_VOLUME(FULL_VOLUME)
) u_bhc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.calm_volume     (out_ch.calm_volume),
	.active_volume   (out_ch.active_volume),
	.mode_now        (out_ch.mode_now),
	.fading          (out_ch.fading),
	.transition_done (out_ch.transition_done)
);
